// File: hdl/box_blur_3x3_rgb_core_assert.svh
// assertion macros for the 3x3 box blur core
// expects signals named clk and arst_n in the module that uses them
`ifndef BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BB3_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bb3 assertion failed");
`define BB3_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bb3 assertion failed");
`else
`define BB3_ASSERT(label, prop)
`define BB3_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/bb3_pkg.sv
// shared constants, types and reciprocal table for the 3x3 box blur core
// no dependencies
`timescale 1ns / 1ps
package bb3_pkg;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int W_W         = $clog2(MAX_WIDTH + 1);
	localparam int H_W         = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
	localparam int CH_W        = 8;
	localparam int PIX_W       = 3 * CH_W;
	localparam int WIN         = 3;
	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int NUM_W       = 13;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 24;
	localparam int CFG_W_W     = 11;
	localparam int CFG_H_W     = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	typedef struct packed {
		logic             valid;
		logic             real_pix;
		logic             emit;
		logic             sel;
		logic             last;
		logic [8:0]       mask;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] pix;
	} tick_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum_r;
		logic [SUM_W-1:0] sum_g;
		logic [SUM_W-1:0] sum_b;
	} sum_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			4'd1: r = 24'd8388608;
			4'd2: r = 24'd4194304;
			4'd3: r = 24'd2796203;
			4'd4: r = 24'd2097152;
			4'd5: r = 24'd1677722;
			4'd6: r = 24'd1398102;
			4'd7: r = 24'd1198373;
			4'd8: r = 24'd1048576;
			4'd9: r = 24'd932068;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// File: hdl/bb3_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module bb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hdl/bb3_ctrl.sv
// raster position counters, frame configuration and tick issue for the box blur
// depends on bb3_pkg and the assertion header
`timescale 1ns / 1ps
`include "box_blur_3x3_rgb_core_assert.svh"
module bb3_ctrl
	import bb3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  s_op,
	input  logic [PIX_W-1:0]      s_pix,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output tick_t                 tick
);
	logic [CFG_W_W-1:0] cfg_w_q;
	logic [CFG_H_W-1:0] cfg_h_q;
	logic [COL_W-1:0]   in_col_q, out_col_q;
	logic [ROW_W-1:0]   in_row_q, out_row_q;
	logic               sec_q;

	logic [W_W-1:0]     w_eff;
	logic [ROW_W-1:0]   h_eff;
	logic [COL_W-1:0]   c;
	logic               row_ge_h, acc, issue, emit1, emit2, emit, last, done;
	logic [2:0]         rowm, colm;
	logic [W_W:0]       oc_w;
	logic [ROW_W:0]     orow_x;
	logic [COL_W-1:0]   in_col_nxt, out_col_nxt;
	logic [ROW_W-1:0]   in_row_nxt, out_row_nxt;

	always_comb begin
		if (cfg_w_q == '0) begin
			w_eff = W_W'(1);
		end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
			w_eff = W_W'(MAX_WIDTH);
		end else begin
			w_eff = W_W'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
			h_eff = ROW_W'(MAX_HEIGHT);
		end else begin
			h_eff = ROW_W'(cfg_h_q);
		end

		c        = (W_W'(in_col_q) >= w_eff) ? '0 : in_col_q;
		row_ge_h = in_row_q >= h_eff;
		s_tready = advance && !sec_q && !cfg_valid;
		acc      = s_tvalid && s_tready;
		issue    = sec_q ? advance : (acc && (row_ge_h || !s_op));

		emit2 = (c == '0) && (in_row_q >= ROW_W'(2));
		emit1 = (c != '0) && (in_row_q >= ROW_W'(1));
		emit  = emit1 || emit2;

		oc_w    = (W_W+1)'(out_col_q);
		orow_x  = (ROW_W+1)'(out_row_q);
		rowm[0] = out_row_q != '0;
		rowm[1] = out_row_q < h_eff;
		rowm[2] = (orow_x + 1'b1) < (ROW_W+1)'(h_eff);
		if (emit1) begin
			colm[0] = out_col_q != '0;
			colm[1] = oc_w < (W_W+1)'(w_eff);
			colm[2] = (oc_w + 1'b1) < (W_W+1)'(w_eff);
		end else begin
			colm[0] = out_col_q >= COL_W'(2);
			colm[1] = out_col_q != '0;
			colm[2] = oc_w < (W_W+1)'(w_eff);
		end
		last = (out_row_q == h_eff - 1'b1) && (oc_w == (W_W+1)'(w_eff) - 1'b1);
		done = emit && last;

		tick.valid    = issue;
		tick.real_pix = !sec_q && !s_op && !row_ge_h;
		tick.emit     = emit;
		tick.sel      = emit1;
		tick.last     = last;
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN; j++) begin
				tick.mask[i*WIN+j] = rowm[i] && colm[j];
			end
		end
		tick.addr = c;
		tick.pix  = s_pix;

		out_col_nxt = out_col_q;
		out_row_nxt = out_row_q;
		if (emit) begin
			if ((oc_w + 1'b1) >= (W_W+1)'(w_eff)) begin
				out_col_nxt = '0;
				out_row_nxt = out_row_q + 1'b1;
			end else begin
				out_col_nxt = out_col_q + 1'b1;
			end
		end
		if ((W_W'(c) + 1'b1) >= w_eff) begin
			in_col_nxt = '0;
			in_row_nxt = in_row_q + 1'b1;
		end else begin
			in_col_nxt = c + 1'b1;
			in_row_nxt = in_row_q;
		end
		if (done) begin
			in_col_nxt  = '0;
			in_row_nxt  = '0;
			out_col_nxt = '0;
			out_row_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q   <= CFG_W_W'(MAX_WIDTH);
			cfg_h_q   <= CFG_H_W'(1024);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			sec_q     <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				cfg_w_q <= cfg_data[CFG_W_W-1:0];
			end else begin
				cfg_h_q <= cfg_data[CFG_H_W-1:0];
			end
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			sec_q     <= 1'b0;
		end else if (issue) begin
			in_col_q  <= in_col_nxt;
			in_row_q  <= in_row_nxt;
			out_col_q <= out_col_nxt;
			out_row_q <= out_row_nxt;
			sec_q     <= !sec_q && !tick.real_pix && !emit && (in_row_nxt >= h_eff);
		end
	end

	`BB3_ASSERT(a_in_col_range, W_W'(in_col_q) < w_eff)
	`BB3_ASSERT(a_out_row_range, out_row_q < h_eff)
	`BB3_ASSERT_NEXT(a_sec_single, sec_q && advance && !cfg_valid, !sec_q)
endmodule

// File: hdl/bb3_win.sv
// line store read-modify-write, 3x3 window and masked channel sums
// depends on bb3_pkg
`timescale 1ns / 1ps
module bb3_win
	import bb3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  tick_t            tick,
	input  logic [PIX_W-1:0] top_rd,
	input  logic [PIX_W-1:0] mid_rd,
	output logic             ls_we,
	output logic [COL_W-1:0] ls_waddr,
	output logic [PIX_W-1:0] up_wdata,
	output logic [PIX_W-1:0] mid_wdata,
	output sum_t             sums
);
	tick_t            t_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_top_q, fwd_mid_q;
	logic [PIX_W-1:0] win_q [WIN][WIN];
	logic [PIX_W-1:0] col4 [WIN][WIN+1];
	logic [PIX_W-1:0] top_e, mid_e, bot_e, px;
	logic [SUM_W-1:0] sr, sg, sb;
	logic [CNT_W-1:0] cnt;

	always_comb begin
		top_e = fwd_s1 ? fwd_top_q : top_rd;
		mid_e = fwd_s1 ? fwd_mid_q : mid_rd;
		bot_e = t_s1.real_pix ? t_s1.pix : '0;
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN; j++) begin
				col4[i][j] = win_q[i][j];
			end
		end
		col4[0][WIN] = top_e;
		col4[1][WIN] = mid_e;
		col4[2][WIN] = bot_e;
		sr = '0;
		sg = '0;
		sb = '0;
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN; j++) begin
				px = t_s1.sel ? col4[i][j+1] : col4[i][j];
				if (t_s1.mask[i*WIN+j]) begin
					sr = sr + SUM_W'(px[CH_W-1:0]);
					sg = sg + SUM_W'(px[2*CH_W-1:CH_W]);
					sb = sb + SUM_W'(px[3*CH_W-1:2*CH_W]);
				end
			end
		end
		cnt = CNT_W'($countones(t_s1.mask));
		if (cnt == '0) begin
			cnt = CNT_W'(1);
		end
		ls_we     = advance && t_s1.valid && t_s1.real_pix;
		ls_waddr  = t_s1.addr;
		up_wdata  = mid_e;
		mid_wdata = t_s1.pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1   <= '0;
			fwd_s1 <= 1'b0;
			sums   <= '0;
			for (int i = 0; i < WIN; i++) begin
				for (int j = 0; j < WIN; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (advance) begin
			t_s1       <= tick;
			fwd_s1     <= tick.valid && ls_we && (tick.addr == t_s1.addr);
			sums.valid <= t_s1.valid && t_s1.emit;
			sums.last  <= t_s1.last;
			sums.cnt   <= cnt;
			sums.sum_r <= sr;
			sums.sum_g <= sg;
			sums.sum_b <= sb;
			if (t_s1.valid) begin
				for (int i = 0; i < WIN; i++) begin
					for (int j = 0; j < WIN; j++) begin
						win_q[i][j] <= col4[i][j+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_top_q <= mid_e;
			fwd_mid_q <= t_s1.pix;
		end
	end
endmodule

// File: hdl/bb3_mean.sv
// rounded mean by fixed reciprocal and the output register
// depends on bb3_pkg
`timescale 1ns / 1ps
module bb3_mean
	import bb3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  sum_t             sums,
	output logic             advance,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [PIX_W-1:0] m_tdata,
	output logic             m_tlast
);
	logic [RECIP_W-1:0]       rc;
	logic [NUM_W-1:0]         nr, ng, nb;
	logic [NUM_W+RECIP_W-1:0] pr, pg, pb;

	always_comb begin
		advance = !m_tvalid || m_tready;
		rc = recip(sums.cnt);
		nr = {sums.sum_r, 1'b0} + NUM_W'(sums.cnt);
		ng = {sums.sum_g, 1'b0} + NUM_W'(sums.cnt);
		nb = {sums.sum_b, 1'b0} + NUM_W'(sums.cnt);
		pr = (NUM_W+RECIP_W)'(nr) * (NUM_W+RECIP_W)'(rc);
		pg = (NUM_W+RECIP_W)'(ng) * (NUM_W+RECIP_W)'(rc);
		pb = (NUM_W+RECIP_W)'(nb) * (NUM_W+RECIP_W)'(rc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= sums.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {pb[RECIP_SHIFT+CH_W-1:RECIP_SHIFT], pg[RECIP_SHIFT+CH_W-1:RECIP_SHIFT],
				pr[RECIP_SHIFT+CH_W-1:RECIP_SHIFT]};
			m_tlast <= sums.last;
		end
	end
endmodule

// File: hdl/box_blur_3x3_rgb_core.sv
// Streaming 3x3 box blur over RGB pixels in raster order. One item is taken per clock
// unless the output stalls or cfg_valid is high; a drain item that ends a single-row
// frame is followed by an internal tick that takes no input. Two line stores in
// block ram are read at the column of each item and written back from the next stage,
// forwarding when the same column is touched back to back. Results lag the input by
// one row plus one pixel; drain items flush the last row. Backpressure on the output
// holds the whole pipeline. The line stores need no clearing after reset.
`timescale 1ns / 1ps
module box_blur_3x3_rgb_core
	import bb3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
	input  logic                  s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic             advance, ls_we;
	tick_t            tick;
	sum_t             sums;
	logic [COL_W-1:0] ls_waddr;
	logic [PIX_W-1:0] top_rd, mid_rd, up_wdata, mid_wdata;

	assign cfg_ready = 1'b1;

	bb3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_op(s_tuser), .s_pix(s_tdata),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data), .tick(tick)
	);

	bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(up_wdata),
		.re(advance), .raddr(tick.addr), .rdata(top_rd)
	);

	bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(mid_wdata),
		.re(advance), .raddr(tick.addr), .rdata(mid_rd)
	);

	bb3_win u_win (
		.clk(clk), .arst_n(arst_n), .advance(advance), .tick(tick),
		.top_rd(top_rd), .mid_rd(mid_rd), .ls_we(ls_we), .ls_waddr(ls_waddr),
		.up_wdata(up_wdata), .mid_wdata(mid_wdata), .sums(sums)
	);

	bb3_mean u_mean (
		.clk(clk), .arst_n(arst_n), .sums(sums), .advance(advance),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);
endmodule
